// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, empty when synthesising
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define HRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hrc assertion failed");

// next-cycle implication
`define HRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hrc assertion failed");

`else

`define HRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define HRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/hrc_pkg.sv =====
// ----------------------------------------------------------------------------
// hrc_pkg
// shared types, constants and arctangent table for the haversine unit
// ----------------------------------------------------------------------------
package hrc_pkg;

    localparam int COUNT_WIDTH  = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);

    localparam int LAT_W     = 28;
    localparam int LON_W     = 29;
    localparam int RAD_W     = 25;
    localparam int CFG_W     = 29;
    localparam int CFG_IDX_W = 2;
    localparam int DEG_W     = 30;
    localparam int MAG_W     = 30;
    localparam int VAL_W     = 36;
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int H_W       = 31;
    localparam int SQ_V_W    = 61;
    localparam int SQ_R_W    = 62;

    typedef logic signed [VAL_W-1:0] t_val;

    localparam t_val PI_Q30         = 36'sd3373259426;
    localparam t_val TWO_PI_Q30     = 36'sd6746518852;
    localparam t_val HALF_PI_Q30    = 36'sd1686629713;
    localparam t_val ONE_Q30        = 36'sd1073741824;
    localparam t_val INV_GAIN_Q30   = 36'sd652032874;
    localparam t_val QUARTER_PI_Q30 = 36'sd843314857;

    localparam logic [H_W-1:0] H_ONE = 31'd1073741824;

    // microdegrees to radians, Q60
    localparam logic [34:0] RAD_FACTOR = 35'd20122259275;
    localparam int          RAD_LO_W   = 18;
    localparam logic [MUL_W-1:0] RAD_F_LO = MUL_W'(RAD_FACTOR[RAD_LO_W-1:0]);
    localparam logic [MUL_W-1:0] RAD_F_HI = MUL_W'(RAD_FACTOR[34:RAD_LO_W]);

    localparam logic [MUL_W-1:0] TWICE_RADIUS_M = 33'd12742000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REF_LAT = 2'd0,
        CFG_REF_LON = 2'd1,
        CFG_RADIUS  = 2'd2
    } t_cfg_idx;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RAD_LO,
        ST_RAD_HI,
        ST_RAD_SUM,
        ST_RAD_SHIFT,
        ST_REDUCE,
        ST_ROT,
        ST_ROT_END,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_MUL4,
        ST_MUL5,
        ST_MUL6,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_VEC,
        ST_DIST1,
        ST_DIST2,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic vec;
    } t_cordic_ctl;

    typedef t_val t_atan_tab [CORDIC_STEPS];

    // shift-subtract division, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int k = 63; k >= 0; k--) begin
            rem = {rem[63:0], num[k]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[k] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(2^-i) in Q30 from a Q60 series
    function automatic t_atan_tab build_atan();
        t_atan_tab         tab;
        logic signed [63:0] sum;
        logic [63:0]        term;
        int                 n;
        logic               neg;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (i == 0) begin
                tab[i] = QUARTER_PI_Q30;
            end else begin
                sum = '0;
                neg = 1'b0;
                n   = 1;
                while (i * n <= 60) begin
                    term = udiv64(64'd1 << (60 - i * n), 64'(n));
                    sum  = neg ? sum - $signed(term) : sum + $signed(term);
                    neg  = !neg;
                    n    = n + 2;
                end
                tab[i] = VAL_W'((sum + 64'sd536870912) >>> 30);
            end
        end
        return tab;
    endfunction

    localparam t_atan_tab ATAN_TAB = build_atan();

endpackage

// ===== sv/hrc_if.sv =====
// ----------------------------------------------------------------------------
// hrc channel interfaces
// valid/ready channels for case points in and distance results out
// ----------------------------------------------------------------------------
interface hrc_in_if;
    logic                                valid;
    logic                                ready;
    logic                                restart;
    logic signed [hrc_pkg::LAT_W-1:0]    case_lat;
    logic signed [hrc_pkg::LON_W-1:0]    case_lon;

    modport source(output valid, restart, case_lat, case_lon, input ready);
    modport sink(input valid, restart, case_lat, case_lon, output ready);
endinterface

interface hrc_out_if;
    logic                              valid;
    logic                              ready;
    logic                              is_near;
    logic [hrc_pkg::RAD_W-1:0]         distance_m;
    logic [15:0]                       near_count;

    modport source(output valid, is_near, distance_m, near_count, input ready);
    modport sink(input valid, is_near, distance_m, near_count, output ready);
endinterface

// ===== sv/hrc_cordic.sv =====
// ----------------------------------------------------------------------------
// hrc_cordic
// shared cordic stage, one micro-rotation per step, rotation or vectoring
// ----------------------------------------------------------------------------
module hrc_cordic (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  hrc_pkg::t_cordic_ctl i_ctl,
    input  hrc_pkg::t_val        i_x0,
    input  hrc_pkg::t_val        i_y0,
    input  hrc_pkg::t_val        i_z0,
    output hrc_pkg::t_val        o_x,
    output hrc_pkg::t_val        o_y,
    output hrc_pkg::t_val        o_z,
    output logic                 o_last
);

    hrc_pkg::t_val r_x, r_y, r_z;
    hrc_pkg::t_val n_x, n_y, n_z;
    logic [hrc_pkg::STEP_W-1:0] r_i, n_i;

    hrc_pkg::t_val w_dx, w_dy, w_ang;
    logic          w_sigma;

    always_comb begin
        w_dx    = r_y >>> r_i;
        w_dy    = r_x >>> r_i;
        w_ang   = hrc_pkg::ATAN_TAB[r_i];
        // rotation follows the residual angle, vectoring drives y to zero
        w_sigma = i_ctl.vec ? !(r_y > hrc_pkg::t_val'(0)) : !r_z[hrc_pkg::VAL_W-1];
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        n_i = r_i;
        if (i_ctl.load) begin
            n_x = i_x0;
            n_y = i_y0;
            n_z = i_z0;
            n_i = '0;
        end else if (i_ctl.step) begin
            n_x = w_sigma ? r_x - w_dx : r_x + w_dx;
            n_y = w_sigma ? r_y + w_dy : r_y - w_dy;
            n_z = w_sigma ? r_z - w_ang : r_z + w_ang;
            n_i = r_i + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
        end else begin
            r_i <= n_i;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_last = (r_i == hrc_pkg::STEP_W'(hrc_pkg::CORDIC_STEPS - 1));

endmodule

// ===== sv/haversine_radius_counter_unit.sv =====
// ----------------------------------------------------------------------------
// haversine_radius_counter_unit
// great-circle distance from a case point to a reference point, near flag
// and saturating near count, on one shared cordic stage and one multiplier
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake       payload
//  i_pt      in    valid/ready     restart, case_lat, case_lon
//  o_res     out   valid/ready     is_near, distance_m, near_count
//  i_cfg     in    write enable    index, data (ref_lat, ref_lon, radius_m)
//
//  one point runs from acceptance to the next ready through four sin/cos
//  rotations and one atan2 vectoring run of 24 cordic steps each, plus two
//  31-step digit-by-digit square roots
//  i_pt.ready is high only while the sequencer is idle
//  a finished result waits in the output register; the next point may be
//  taken meanwhile and stalls only at its own final write
//  reset is synchronous, active low; it clears the state, the configuration registers, output valid and the near count
//
`include "assert_macros.svh"

module haversine_radius_counter_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    hrc_in_if.sink                        i_pt,
    hrc_out_if.source                     o_res,
    input  logic                          i_cfg_wr_en,
    input  logic [hrc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [hrc_pkg::CFG_W-1:0]     i_cfg_data
);

    // ------------------------------------------------------------------
    // clamp helpers
    // ------------------------------------------------------------------
    function automatic hrc_pkg::t_val clamp_unit(input hrc_pkg::t_val v);
        if (v < -hrc_pkg::ONE_Q30) return -hrc_pkg::ONE_Q30;
        if (v > hrc_pkg::ONE_Q30)  return hrc_pkg::ONE_Q30;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    hrc_pkg::t_state r_state, n_state;

    logic signed [hrc_pkg::LAT_W-1:0] r_ref_lat;
    logic signed [hrc_pkg::LON_W-1:0] r_ref_lon;
    logic [hrc_pkg::RAD_W-1:0]        r_radius;
    logic [hrc_pkg::COUNT_WIDTH-1:0]  r_count;

    logic                             r_restart;
    logic signed [hrc_pkg::LAT_W-1:0] r_clat;
    logic signed [hrc_pkg::LON_W-1:0] r_clon;

    logic [1:0]                r_k;          // angle job: dlat, dlon, case lat, ref lat
    logic [hrc_pkg::MAG_W-1:0] r_mag;
    logic                      r_neg;
    logic [63:0]               r_acc;
    hrc_pkg::t_val             r_th;
    logic                      r_flip;
    hrc_pkg::t_val             r_s1, r_s2, r_c1, r_c2;
    hrc_pkg::t_val             r_m1, r_m2, r_m3;
    logic [hrc_pkg::H_W-1:0]   r_h;

    logic [hrc_pkg::SQ_V_W-1:0] r_sq_v;
    logic [hrc_pkg::SQ_R_W-1:0] r_sq_res;
    logic [hrc_pkg::SQ_V_W-1:0] r_sq_bit;
    logic                       r_sq_sel;
    logic [hrc_pkg::H_W-1:0]    r_sq_y;

    logic signed [hrc_pkg::PROD_W-1:0] r_prod;

    logic [hrc_pkg::RAD_W-1:0] r_dist;
    logic                      r_near;

    logic                            r_out_valid;
    logic                            r_out_near;
    logic [hrc_pkg::RAD_W-1:0]       r_out_dist;
    logic [hrc_pkg::COUNT_WIDTH-1:0] r_out_count;

    // ------------------------------------------------------------------
    // shared cordic stage
    // ------------------------------------------------------------------
    hrc_pkg::t_cordic_ctl w_cctl;
    hrc_pkg::t_val        w_cx0, w_cy0, w_cz0;
    hrc_pkg::t_val        w_cx, w_cy, w_cz;
    logic                 w_clast;

    hrc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_cctl),
        .i_x0    (w_cx0),
        .i_y0    (w_cy0),
        .i_z0    (w_cz0),
        .o_x     (w_cx),
        .o_y     (w_cy),
        .o_z     (w_cz),
        .o_last  (w_clast)
    );

    // ------------------------------------------------------------------
    // combinational datapath pieces
    // ------------------------------------------------------------------
    logic signed [hrc_pkg::DEG_W-1:0]  w_deg;
    logic [hrc_pkg::MAG_W-1:0]         w_mag;
    logic [63:0]                       w_sh;
    hrc_pkg::t_val                     w_th_abs;
    hrc_pkg::t_val                     w_fold_z;
    logic                              w_fold_flip;
    hrc_pkg::t_val                     w_xf;
    hrc_pkg::t_val                     w_rnd;
    hrc_pkg::t_val                     w_hsum;
    logic [hrc_pkg::H_W-1:0]           w_h;
    logic [hrc_pkg::SQ_R_W-1:0]        w_sq_try;
    logic                              w_sq_ge;
    logic [hrc_pkg::SQ_V_W-1:0]        w_sq_nv;
    logic [hrc_pkg::SQ_R_W-1:0]        w_sq_nres;
    hrc_pkg::t_val                     w_ang;
    logic signed [hrc_pkg::MUL_W-1:0]  w_mul_a, w_mul_b;
    logic [hrc_pkg::COUNT_WIDTH-1:0]   w_cnt_base;
    logic [hrc_pkg::COUNT_WIDTH-1:0]   w_cnt_next;
    logic                              w_fire;

    always_comb begin
        // microdegree source of the current angle job
        case (r_k)
            2'd0:    w_deg = {{2{r_ref_lat[hrc_pkg::LAT_W-1]}}, r_ref_lat}
                             - {{2{r_clat[hrc_pkg::LAT_W-1]}}, r_clat};
            2'd1:    w_deg = {r_ref_lon[hrc_pkg::LON_W-1], r_ref_lon}
                             - {r_clon[hrc_pkg::LON_W-1], r_clon};
            2'd2:    w_deg = {{2{r_clat[hrc_pkg::LAT_W-1]}}, r_clat};
            default: w_deg = {{2{r_ref_lat[hrc_pkg::LAT_W-1]}}, r_ref_lat};
        endcase
        w_mag = w_deg[hrc_pkg::DEG_W-1] ? hrc_pkg::MAG_W'(-w_deg) : hrc_pkg::MAG_W'(w_deg);

        // differences give half angles (extra bit of shift)
        w_sh     = r_k[1] ? (r_acc >> 30) : (r_acc >> 31);
        w_th_abs = hrc_pkg::VAL_W'(w_sh);

        // fold into [-pi/2, pi/2]
        w_fold_z    = r_th;
        w_fold_flip = 1'b0;
        if (r_th > hrc_pkg::HALF_PI_Q30) begin
            w_fold_z    = hrc_pkg::PI_Q30 - r_th;
            w_fold_flip = 1'b1;
        end else if (r_th < -hrc_pkg::HALF_PI_Q30) begin
            w_fold_z    = -hrc_pkg::PI_Q30 - r_th;
            w_fold_flip = 1'b1;
        end

        w_xf = r_flip ? -w_cx : w_cx;

        // q60 product rounded back to q30
        w_rnd = hrc_pkg::VAL_W'((r_prod + hrc_pkg::PROD_W'(64'sd536870912)) >>> 30);

        w_hsum = r_m1 + w_rnd;
        if (w_hsum[hrc_pkg::VAL_W-1]) begin
            w_h = '0;
        end else if (w_hsum > hrc_pkg::ONE_Q30) begin
            w_h = hrc_pkg::H_ONE;
        end else begin
            w_h = hrc_pkg::H_W'(w_hsum);
        end

        // one root digit per cycle
        w_sq_try  = r_sq_res + hrc_pkg::SQ_R_W'(r_sq_bit);
        w_sq_ge   = hrc_pkg::SQ_R_W'(r_sq_v) >= w_sq_try;
        w_sq_nv   = w_sq_ge ? r_sq_v - hrc_pkg::SQ_V_W'(w_sq_try) : r_sq_v;
        w_sq_nres = w_sq_ge ? (r_sq_res >> 1) + hrc_pkg::SQ_R_W'(r_sq_bit) : (r_sq_res >> 1);

        // final angle kept within [0, pi/2]
        if (w_cz[hrc_pkg::VAL_W-1]) begin
            w_ang = '0;
        end else if (w_cz > hrc_pkg::HALF_PI_Q30) begin
            w_ang = hrc_pkg::HALF_PI_Q30;
        end else begin
            w_ang = w_cz;
        end

        w_cnt_base = r_restart ? '0 : r_count;
        w_cnt_next = (r_near && (w_cnt_base != '1)) ? w_cnt_base + 1'b1 : w_cnt_base;

        w_fire = (r_state == hrc_pkg::ST_DONE) && (!r_out_valid || o_res.ready);
    end

    // ------------------------------------------------------------------
    // sequencer: next state, multiplier operands, cordic control
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        w_mul_a = '0;
        w_mul_b = '0;
        w_cctl  = '0;
        w_cx0   = hrc_pkg::INV_GAIN_Q30;
        w_cy0   = '0;
        w_cz0   = w_fold_z;
        unique case (r_state)
            hrc_pkg::ST_IDLE: begin
                if (i_pt.valid) n_state = hrc_pkg::ST_RAD_LO;
            end
            hrc_pkg::ST_RAD_LO: begin
                w_mul_a = hrc_pkg::MUL_W'(w_mag);
                w_mul_b = hrc_pkg::RAD_F_LO;
                n_state = hrc_pkg::ST_RAD_HI;
            end
            hrc_pkg::ST_RAD_HI: begin
                w_mul_a = hrc_pkg::MUL_W'(r_mag);
                w_mul_b = hrc_pkg::RAD_F_HI;
                n_state = hrc_pkg::ST_RAD_SUM;
            end
            hrc_pkg::ST_RAD_SUM:   n_state = hrc_pkg::ST_RAD_SHIFT;
            hrc_pkg::ST_RAD_SHIFT: n_state = hrc_pkg::ST_REDUCE;
            hrc_pkg::ST_REDUCE: begin
                // one turn of 2*pi per cycle until inside [-pi, pi]
                if (!(r_th > hrc_pkg::PI_Q30) && !(r_th < -hrc_pkg::PI_Q30)) begin
                    w_cctl.load = 1'b1;
                    n_state     = hrc_pkg::ST_ROT;
                end
            end
            hrc_pkg::ST_ROT: begin
                w_cctl.step = 1'b1;
                if (w_clast) n_state = hrc_pkg::ST_ROT_END;
            end
            hrc_pkg::ST_ROT_END: begin
                n_state = (r_k == 2'd3) ? hrc_pkg::ST_MUL1 : hrc_pkg::ST_RAD_LO;
            end
            hrc_pkg::ST_MUL1: begin
                w_mul_a = hrc_pkg::MUL_W'(r_s1);
                w_mul_b = hrc_pkg::MUL_W'(r_s1);
                n_state = hrc_pkg::ST_MUL2;
            end
            hrc_pkg::ST_MUL2: begin
                w_mul_a = hrc_pkg::MUL_W'(r_c1);
                w_mul_b = hrc_pkg::MUL_W'(r_c2);
                n_state = hrc_pkg::ST_MUL3;
            end
            hrc_pkg::ST_MUL3: begin
                w_mul_a = hrc_pkg::MUL_W'(r_s2);
                w_mul_b = hrc_pkg::MUL_W'(r_s2);
                n_state = hrc_pkg::ST_MUL4;
            end
            hrc_pkg::ST_MUL4: n_state = hrc_pkg::ST_MUL5;
            hrc_pkg::ST_MUL5: begin
                w_mul_a = hrc_pkg::MUL_W'(r_m2);
                w_mul_b = hrc_pkg::MUL_W'(r_m3);
                n_state = hrc_pkg::ST_MUL6;
            end
            hrc_pkg::ST_MUL6:      n_state = hrc_pkg::ST_SQRT_INIT;
            hrc_pkg::ST_SQRT_INIT: n_state = hrc_pkg::ST_SQRT;
            hrc_pkg::ST_SQRT: begin
                if (r_sq_bit[0]) begin
                    if (!r_sq_sel) begin
                        n_state = hrc_pkg::ST_SQRT_INIT;
                    end else begin
                        // start vectoring from (x, y) = (root of 1-h, root of h)
                        w_cctl.load = 1'b1;
                        w_cctl.vec  = 1'b1;
                        w_cx0       = hrc_pkg::VAL_W'(w_sq_nres);
                        w_cy0       = hrc_pkg::VAL_W'(r_sq_y);
                        w_cz0       = '0;
                        n_state     = (r_sq_y == '0) ? hrc_pkg::ST_DIST1 : hrc_pkg::ST_VEC;
                    end
                end
            end
            hrc_pkg::ST_VEC: begin
                w_cctl.step = 1'b1;
                w_cctl.vec  = 1'b1;
                if (w_clast) n_state = hrc_pkg::ST_DIST1;
            end
            hrc_pkg::ST_DIST1: begin
                w_mul_a = hrc_pkg::MUL_W'(w_ang);
                w_mul_b = hrc_pkg::TWICE_RADIUS_M;
                n_state = hrc_pkg::ST_DIST2;
            end
            hrc_pkg::ST_DIST2: n_state = hrc_pkg::ST_DONE;
            hrc_pkg::ST_DONE: begin
                if (w_fire) n_state = hrc_pkg::ST_IDLE;
            end
            default: n_state = hrc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hrc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // configuration registers, near count and output handshake
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_lat   <= '0;
            r_ref_lon   <= '0;
            r_radius    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    hrc_pkg::CFG_REF_LAT: r_ref_lat <= hrc_pkg::LAT_W'(i_cfg_data);
                    hrc_pkg::CFG_REF_LON: r_ref_lon <= i_cfg_data;
                    hrc_pkg::CFG_RADIUS:  r_radius  <= hrc_pkg::RAD_W'(i_cfg_data);
                    default: ;
                endcase
            end
            if (w_fire) begin
                r_count     <= w_cnt_next;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded with the transaction that completes a point
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_near  <= r_near;
            r_out_dist  <= r_dist;
            r_out_count <= w_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_prod <= hrc_pkg::PROD_W'(w_mul_a) * hrc_pkg::PROD_W'(w_mul_b);
        case (r_state)
            hrc_pkg::ST_IDLE: begin
                r_restart <= i_pt.restart;
                r_clat    <= i_pt.case_lat;
                r_clon    <= i_pt.case_lon;
                r_k       <= 2'd0;
                r_sq_sel  <= 1'b0;
            end
            hrc_pkg::ST_RAD_LO: begin
                r_mag <= w_mag;
                r_neg <= w_deg[hrc_pkg::DEG_W-1];
            end
            hrc_pkg::ST_RAD_HI: begin
                // rounding half of the final shift
                r_acc <= r_prod[63:0] + (r_k[1] ? 64'd536870912 : 64'd1073741824);
            end
            hrc_pkg::ST_RAD_SUM: begin
                r_acc <= r_acc + {r_prod[45:0], 18'b0};
            end
            hrc_pkg::ST_RAD_SHIFT: begin
                r_th <= r_neg ? -w_th_abs : w_th_abs;
            end
            hrc_pkg::ST_REDUCE: begin
                if (r_th > hrc_pkg::PI_Q30) begin
                    r_th <= r_th - hrc_pkg::TWO_PI_Q30;
                end else if (r_th < -hrc_pkg::PI_Q30) begin
                    r_th <= r_th + hrc_pkg::TWO_PI_Q30;
                end else begin
                    r_flip <= w_fold_flip;
                end
            end
            hrc_pkg::ST_ROT_END: begin
                case (r_k)
                    2'd0:    r_s1 <= clamp_unit(w_cy);
                    2'd1:    r_s2 <= clamp_unit(w_cy);
                    2'd2:    r_c1 <= clamp_unit(w_xf);
                    default: r_c2 <= clamp_unit(w_xf);
                endcase
                r_k <= r_k + 1'b1;
            end
            hrc_pkg::ST_MUL2: r_m1 <= w_rnd;
            hrc_pkg::ST_MUL3: r_m2 <= w_rnd;
            hrc_pkg::ST_MUL4: r_m3 <= w_rnd;
            hrc_pkg::ST_MUL6: r_h  <= w_h;
            hrc_pkg::ST_SQRT_INIT: begin
                r_sq_v   <= r_sq_sel ? {hrc_pkg::H_ONE - r_h, 30'b0} : {r_h, 30'b0};
                r_sq_res <= '0;
                r_sq_bit <= {1'b1, {(hrc_pkg::SQ_V_W - 1){1'b0}}};
            end
            hrc_pkg::ST_SQRT: begin
                r_sq_v   <= w_sq_nv;
                r_sq_res <= w_sq_nres;
                r_sq_bit <= r_sq_bit >> 2;
                if (r_sq_bit[0] && !r_sq_sel) begin
                    r_sq_y   <= hrc_pkg::H_W'(w_sq_nres);
                    r_sq_sel <= 1'b1;
                end
            end
            hrc_pkg::ST_DIST2: begin
                r_dist <= r_prod[54:30];
                r_near <= r_prod[54:30] < r_radius;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // ports
    // ------------------------------------------------------------------
    assign i_pt.ready       = (r_state == hrc_pkg::ST_IDLE);
    assign o_res.valid      = r_out_valid;
    assign o_res.is_near    = r_out_near;
    assign o_res.distance_m = r_out_dist;
    assign o_res.near_count = r_out_count;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // an accepted point always starts the sequencer
    `HRC_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, i_pt.valid && i_pt.ready, r_state == hrc_pkg::ST_RAD_LO)
    // haversine term lands inside [0, 1]
    `HRC_ASSERT_NXT(a_h_in_range, i_clk, i_rst_n, r_state == hrc_pkg::ST_MUL6, r_h <= hrc_pkg::H_ONE)
    // vectoring keeps x non-negative
    `HRC_ASSERT_IMP(a_vec_x_pos, i_clk, i_rst_n, r_state == hrc_pkg::ST_VEC, !w_cx[hrc_pkg::VAL_W-1])

endmodule
